@@ rtl/lgtmd_pkg.sv @@
// Package for the LED grid time marker decoder.
// Holds the grid geometry, status codes, the result type and the grid helper functions.
// Has no dependencies.
package lgtmd_pkg;

	localparam int GRID_SIZE = 8;
	localparam int GRID_LAST = GRID_SIZE - 1;
	localparam int GRID_BITS = GRID_SIZE * GRID_SIZE;
	localparam int THR_W = 5;
	localparam int CNT_W = 6;
	localparam logic [THR_W-1:0] THR_RESET = 5'd25;
	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 32;
	localparam logic [2:0] CORNER_LIT_COUNT = 3'd3;
	localparam logic [3:0] TENS_MAX = 4'd6;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_MARKER = 2'd1,
		STATUS_DIGITS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_90 = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef struct packed {
		logic [1:0] rotation;
		logic second_flash;
		logic [3:0] digit_valid;
		logic [7:0] seconds;
		logic [7:0] minutes;
		status_t status;
	} result_t;

	function automatic logic [5:0] cell_idx(input int r, input int c);
		int idx;
		idx = r * GRID_SIZE + c;
		return idx[5:0];
	endfunction

	// Rotates the whole grid so that cell (j,i) of the result is read from the source map.
	function automatic logic [GRID_BITS-1:0] rotate_grid(input logic [GRID_BITS-1:0] g,
			input rot_t rot);
		logic [GRID_BITS-1:0] res;
		res = '0;
		for (int j = 0; j < GRID_SIZE; j++) begin
			for (int i = 0; i < GRID_SIZE; i++) begin
				unique case (rot)
					ROT_90: res[cell_idx(j, i)] = g[cell_idx(GRID_LAST - i, j)];
					ROT_180: res[cell_idx(j, i)] = g[cell_idx(GRID_LAST - j, GRID_LAST - i)];
					ROT_270: res[cell_idx(j, i)] = g[cell_idx(i, GRID_LAST - j)];
					default: res[cell_idx(j, i)] = g[cell_idx(j, i)];
				endcase
			end
		end
		return res;
	endfunction

	// Counts the lit border cells; the four grid corners are counted twice.
	function automatic logic [CNT_W-1:0] border_count(input logic [GRID_BITS-1:0] g);
		logic [CNT_W-1:0] cnt;
		cnt = '0;
		for (int k = 0; k < GRID_SIZE; k++) begin
			cnt = cnt + CNT_W'(g[cell_idx(0, k)]) + CNT_W'(g[cell_idx(GRID_LAST, k)])
				+ CNT_W'(g[cell_idx(k, 0)]) + CNT_W'(g[cell_idx(k, GRID_LAST)]);
		end
		return cnt;
	endfunction

	function automatic logic [3:0] digit_at(input logic [GRID_BITS-1:0] g, input int r);
		return {g[cell_idx(r, 2)], g[cell_idx(r, 3)], g[cell_idx(r, 4)], g[cell_idx(r, 5)]};
	endfunction

	// An even digit needs the right parity cell lit and the left one dark; odd is the reverse.
	function automatic logic parity_ok(input logic [GRID_BITS-1:0] g, input int r,
			input logic [3:0] d);
		logic right_c;
		logic left_c;
		right_c = g[cell_idx(r, GRID_SIZE - 2)];
		left_c = g[cell_idx(r, 1)];
		return d[0] ? (!right_c && left_c) : (right_c && !left_c);
	endfunction

	function automatic logic [7:0] times_ten(input logic [3:0] d);
		return {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
	endfunction

endpackage

@@ rtl/led_grid_time_marker_decoder_unit.sv @@
// Top level of the LED grid time marker decoder.
// Depends on lgtmd_pkg for geometry, status codes and grid helper functions.
//
// Usage: one 8x8 grid word enters on the s_axis channel, with cell (r,c) at bit r*8+c.
// One result word leaves on the m_axis channel for every grid word taken.
// The border threshold is written through the cfg channel, which is always ready;
// it must only be written while no word is in flight.
// The grid word is captured in an input register on acceptance, and the whole decode (border
// count, corner check, rotation, digit and parity checks) sits between that register and the
// result register, which drives m_axis_tvalid.
// Throughput is one word per cycle while the receiver does not stall. While it stalls, the
// result register holds its word, the input register still takes one more word, and
// s_axis_tready then drops until the result is taken.
// Reset empties both registers and sets the border threshold to 25.
module led_grid_time_marker_decoder_unit
	import lgtmd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [IN_DATA_W-1:0] s_axis_tdata, // grid_bits[63:0]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[1:0], minutes[9:2], seconds[17:10], digit_valid[21:18],
	// second_flash[22], rotation[24:23], zero fill above
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [THR_W-1:0] cfg_data // border_threshold[4:0]
);

	logic [THR_W-1:0] thr_q;
	logic valid_s1;
	logic [GRID_BITS-1:0] grid_s1;
	logic valid_s2;
	result_t res_s2;
	logic adv_s2;
	logic adv_s1;
	result_t res_d;

	logic [CNT_W-1:0] bcnt;
	logic c0, c1, c2, c3;
	logic [2:0] csum;
	logic marker_bad;
	rot_t rot;
	logic [GRID_BITS-1:0] rg;
	logic [3:0] d [4];
	logic [3:0] v;
	logic [2:0] fsum;

	assign cfg_ready = 1'b1;
	assign adv_s2 = !valid_s2 || m_axis_tready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_comb begin
		bcnt = border_count(grid_s1);
		c0 = grid_s1[cell_idx(1, 1)];
		c1 = grid_s1[cell_idx(1, GRID_SIZE - 2)];
		c2 = grid_s1[cell_idx(GRID_SIZE - 2, 1)];
		c3 = grid_s1[cell_idx(GRID_SIZE - 2, GRID_SIZE - 2)];
		csum = 3'(c0) + 3'(c1) + 3'(c2) + 3'(c3);
		// Adjusted count below threshold is the raw count below threshold plus four.
		marker_bad = (bcnt < ({1'b0, thr_q} + CNT_W'(4))) || (csum != CORNER_LIT_COUNT);
		priority if (!c0) begin
			rot = ROT_180;
		end else if (!c1) begin
			rot = ROT_90;
		end else if (!c2) begin
			rot = ROT_270;
		end else begin
			rot = ROT_NONE;
		end
		rg = rotate_grid(grid_s1, rot);
		for (int k = 0; k < 4; k++) begin
			d[k] = digit_at(rg, k + 2);
			v[3 - k] = parity_ok(rg, k + 2, d[k]);
		end
		if (d[0] > TENS_MAX) begin
			v[3] = 1'b0;
		end
		if (d[2] > TENS_MAX) begin
			v[1] = 1'b0;
		end
		fsum = 3'(rg[cell_idx(1, 2)]) + 3'(rg[cell_idx(1, 3)])
			+ 3'(rg[cell_idx(GRID_SIZE - 2, 4)]) + 3'(rg[cell_idx(GRID_SIZE - 2, 5)]);
		if (marker_bad) begin
			res_d = '0;
			res_d.status = STATUS_MARKER;
		end else begin
			res_d.status = (v == 4'hF) ? STATUS_OK : STATUS_DIGITS;
			res_d.minutes = times_ten(d[0]) + {4'b0000, d[1]};
			res_d.seconds = times_ten(d[2]) + {4'b0000, d[3]};
			res_d.digit_valid = v;
			res_d.second_flash = (fsum >= 3'd2);
			res_d.rotation = rot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			grid_s1 <= s_axis_tdata;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {(OUT_DATA_W - $bits(result_t))'(0), res_s2};

	a_marker_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.status == STATUS_MARKER) |->
		(res_s2.minutes == '0 && res_s2.seconds == '0 && res_s2.digit_valid == '0
		&& !res_s2.second_flash && res_s2.rotation == '0))
		else $error("marker invalid result carries nonzero fields");

	a_ok_all_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.status == STATUS_OK) |-> (res_s2.digit_valid == 4'hF))
		else $error("valid status with an invalid digit");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while both registers are full and stalled");

	a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_axis_tvalid && !m_axis_tready) |=> valid_s1)
		else $error("buffered word lost during a stall");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for led_grid_time_marker_decoder_unit.
// A directed table and constrained-shape random grids are checked against a local decoder model.
// Depends on lgtmd_pkg and the top-level RTL only.
module tb
	import lgtmd_pkg::*;
();

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 143;
	localparam result_t MARKER_REJECT = '{rotation: 2'd0, second_flash: 1'b0,
		digit_valid: 4'd0, seconds: 8'd0, minutes: 8'd0, status: STATUS_MARKER};

	typedef struct {
		bit is_write;
		logic [THR_W-1:0] thr;
		logic [IN_DATA_W-1:0] grid;
		bit known;
		result_t want;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0; // grid_bits[63:0]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// status[1:0], minutes[9:2], seconds[17:10], digit_valid[21:18],
	// second_flash[22], rotation[24:23], zero fill above
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THR_W-1:0] cfg_data = '0; // border_threshold[4:0]

	result_t expected_times[$];
	plan_row_t plan[$];
	logic [THR_W-1:0] border_threshold = THR_RESET;
	int fail_count = 0;
	int stall_left = 0;
	int cycle_count;
	bit quiet = 1'b0;

	led_grid_time_marker_decoder_unit i_dut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.cfg_valid,
		.cfg_ready,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int cell_at(input int r, input int c);
		return r * GRID_SIZE + c;
	endfunction

	function automatic logic rotated_cell(input logic [IN_DATA_W-1:0] g, input rot_t rot,
			input int j, input int i);
		case (rot)
			ROT_90: return g[cell_at(GRID_LAST - i, j)];
			ROT_180: return g[cell_at(GRID_LAST - j, GRID_LAST - i)];
			ROT_270: return g[cell_at(i, GRID_LAST - j)];
			default: return g[cell_at(j, i)];
		endcase
	endfunction

	function automatic result_t decode_marker(input logic [IN_DATA_W-1:0] g,
			input logic [THR_W-1:0] thr);
		int lit_border;
		int corner_sum;
		int flash_sum;
		logic c0, c1, c2, c3, right_c, left_c;
		logic [3:0] dg [4];
		logic [3:0] ok;
		rot_t rot;
		result_t r;
		lit_border = -4;
		for (int k = 0; k < GRID_SIZE; k++) begin
			lit_border = lit_border + g[cell_at(0, k)] + g[cell_at(GRID_LAST, k)]
				+ g[cell_at(k, 0)] + g[cell_at(k, GRID_LAST)];
		end
		c0 = g[cell_at(1, 1)];
		c1 = g[cell_at(1, GRID_LAST - 1)];
		c2 = g[cell_at(GRID_LAST - 1, 1)];
		c3 = g[cell_at(GRID_LAST - 1, GRID_LAST - 1)];
		corner_sum = c0 + c1 + c2 + c3;
		if (lit_border < int'(thr) || corner_sum != 3)
			return MARKER_REJECT;
		if (!c0)
			rot = ROT_180;
		else if (!c1)
			rot = ROT_90;
		else if (!c2)
			rot = ROT_270;
		else
			rot = ROT_NONE;
		for (int k = 0; k < 4; k++) begin
			dg[k] = {rotated_cell(g, rot, 2 + k, 2), rotated_cell(g, rot, 2 + k, 3),
				rotated_cell(g, rot, 2 + k, 4), rotated_cell(g, rot, 2 + k, 5)};
			right_c = rotated_cell(g, rot, 2 + k, GRID_LAST - 1);
			left_c = rotated_cell(g, rot, 2 + k, 1);
			ok[3 - k] = dg[k][0] ? (!right_c && left_c) : (right_c && !left_c);
		end
		if (dg[0] > 4'd6)
			ok[3] = 1'b0;
		if (dg[2] > 4'd6)
			ok[1] = 1'b0;
		flash_sum = rotated_cell(g, rot, 1, 2) + rotated_cell(g, rot, 1, 3)
			+ rotated_cell(g, rot, GRID_LAST - 1, 4) + rotated_cell(g, rot, GRID_LAST - 1, 5);
		r.status = (ok == 4'hF) ? STATUS_OK : STATUS_DIGITS;
		r.minutes = 8'(dg[0] * 10 + dg[1]);
		r.seconds = 8'(dg[2] * 10 + dg[3]);
		r.digit_valid = ok;
		r.second_flash = (flash_sum >= 2);
		r.rotation = rot;
		return r;
	endfunction

	// Builds a marker upright (dark inner corner at row 6, column 6) and then turns it so
	// that the decoder has to apply the given rotation to read it back.
	function automatic logic [IN_DATA_W-1:0] compose_marker(input logic [15:0] digits,
			input logic [3:0] bad, input logic [3:0] flash, input int dark, input rot_t orient);
		logic [IN_DATA_W-1:0] c;
		logic [IN_DATA_W-1:0] g;
		logic [3:0] d;
		logic [1:0] pair;
		int pick;
		c = {$urandom, $urandom};
		for (int k = 0; k < GRID_SIZE; k++) begin
			c[cell_at(0, k)] = 1'b1;
			c[cell_at(GRID_LAST, k)] = 1'b1;
			c[cell_at(k, 0)] = 1'b1;
			c[cell_at(k, GRID_LAST)] = 1'b1;
		end
		c[cell_at(1, 1)] = 1'b1;
		c[cell_at(1, 6)] = 1'b1;
		c[cell_at(6, 1)] = 1'b1;
		c[cell_at(6, 6)] = 1'b0;
		c[cell_at(1, 2)] = flash[0];
		c[cell_at(1, 3)] = flash[1];
		c[cell_at(6, 4)] = flash[2];
		c[cell_at(6, 5)] = flash[3];
		for (int k = 0; k < 4; k++) begin
			d = digits[15 - 4 * k -: 4];
			c[cell_at(2 + k, 2)] = d[3];
			c[cell_at(2 + k, 3)] = d[2];
			c[cell_at(2 + k, 4)] = d[1];
			c[cell_at(2 + k, 5)] = d[0];
			pair = d[0] ? 2'b01 : 2'b10;
			if (bad[3 - k])
				pair = pair ^ 2'($urandom_range(1, 3));
			c[cell_at(2 + k, 6)] = pair[1];
			c[cell_at(2 + k, 1)] = pair[0];
		end
		repeat (dark) begin
			pick = $urandom_range(0, GRID_LAST);
			case ($urandom_range(0, 3))
				0: c[cell_at(0, pick)] = 1'b0;
				1: c[cell_at(GRID_LAST, pick)] = 1'b0;
				2: c[cell_at(pick, 0)] = 1'b0;
				default: c[cell_at(pick, GRID_LAST)] = 1'b0;
			endcase
		end
		for (int j = 0; j < GRID_SIZE; j++) begin
			for (int i = 0; i < GRID_SIZE; i++) begin
				case (orient)
					ROT_90: g[cell_at(GRID_LAST - i, j)] = c[cell_at(j, i)];
					ROT_180: g[cell_at(GRID_LAST - j, GRID_LAST - i)] = c[cell_at(j, i)];
					ROT_270: g[cell_at(i, GRID_LAST - j)] = c[cell_at(j, i)];
					default: g[cell_at(j, i)] = c[cell_at(j, i)];
				endcase
			end
		end
		return g;
	endfunction

	// Mostly well-formed markers; some with broken inner corners, some pure noise.
	function automatic logic [IN_DATA_W-1:0] random_grid();
		logic [IN_DATA_W-1:0] g;
		logic [15:0] digits;
		logic [3:0] bad;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return {$urandom, $urandom};
		for (int k = 0; k < 4; k++) begin
			if (k % 2 == 0 && $urandom_range(0, 9) < 8)
				digits[15 - 4 * k -: 4] = 4'($urandom_range(0, 6));
			else
				digits[15 - 4 * k -: 4] = 4'($urandom_range(0, 15));
		end
		bad = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'b0000;
		g = compose_marker(digits, bad, 4'($urandom),
			($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : $urandom_range(0, 2),
			rot_t'($urandom_range(0, 3)));
		if (r < 25) begin
			g[cell_at(1, 1)] = 1'($urandom_range(0, 1));
			g[cell_at(1, 6)] = 1'($urandom_range(0, 1));
			g[cell_at(6, 1)] = 1'($urandom_range(0, 1));
			g[cell_at(6, 6)] = 1'($urandom_range(0, 1));
		end
		return g;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic plan_item(input logic [IN_DATA_W-1:0] g, input bit known,
			input result_t want);
		plan_row_t row;
		row = '{1'b0, '0, g, known, want};
		plan.insert(plan.size(), row);
	endtask

	task automatic plan_write(input logic [THR_W-1:0] thr);
		plan_row_t row;
		row = '{1'b1, thr, '0, 1'b0, MARKER_REJECT};
		plan.insert(plan.size(), row);
	endtask

	// The threshold only changes once every expected word has come back.
	task automatic set_threshold(input logic [THR_W-1:0] thr);
		s_axis_tvalid <= 1'b0;
		while (expected_times.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		border_threshold = thr;
	endtask

	task automatic feed_grid(input logic [IN_DATA_W-1:0] g, input bit known,
			input result_t want);
		int gap;
		result_t exp_word;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= g;
		do @(posedge clk); while (!s_axis_tready);
		exp_word = known ? want : decode_marker(g, border_threshold);
		expected_times.insert(expected_times.size(), exp_word);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	task automatic take_word();
		result_t got;
		result_t want;
		got = m_axis_tdata[$bits(result_t)-1:0];
		if (expected_times.size() == 0) begin
			$display("%0t: result word with nothing expected, expected none, actual %h",
				$time, m_axis_tdata);
			fail_count++;
		end else begin
			want = expected_times.pop_front();
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("minutes", 32'(want.minutes), 32'(got.minutes));
			check_field("seconds", 32'(want.seconds), 32'(got.seconds));
			check_field("digit_valid", 32'(want.digit_valid), 32'(got.digit_valid));
			check_field("second_flash", 32'(want.second_flash), 32'(got.second_flash));
			check_field("rotation", 32'(want.rotation), 32'(got.rotation));
			check_field("zero fill", '0,
				32'(m_axis_tdata[OUT_DATA_W-1:$bits(result_t)]));
		end
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			take_word();
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("led_grid_time_marker_decoder_unit regression: fail");
		$finish;
	end

	initial begin
		logic [IN_DATA_W-1:0] g;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		plan_item('0, 1'b1, MARKER_REJECT);
		plan_item('1, 1'b1, MARKER_REJECT);
		plan_item(compose_marker(16'h5959, 4'b0000, 4'b0000, 0, ROT_NONE), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h6969, 4'b0000, 4'b1111, 0, ROT_90), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h0000, 4'b0000, 4'b0011, 0, ROT_180), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'hFFFF, 4'b0000, 4'b0001, 0, ROT_270), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h7070, 4'b0000, 4'b0101, 1, ROT_NONE), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h2413, 4'b1010, 4'b0110, 0, ROT_90), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h3058, 4'b1111, 4'b1000, 0, ROT_180), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h1234, 4'b0000, 4'b1100, 3, ROT_270), 1'b0, MARKER_REJECT);
		// All four inner corners lit, then only two of them lit.
		g = compose_marker(16'h4321, 4'b0000, 4'b0000, 0, ROT_NONE);
		g[cell_at(6, 6)] = 1'b1;
		plan_item(g, 1'b1, MARKER_REJECT);
		g[cell_at(6, 6)] = 1'b0;
		g[cell_at(1, 1)] = 1'b0;
		plan_item(g, 1'b1, MARKER_REJECT);
		// A full border just reaches the highest meaningful threshold.
		plan_write(5'd28);
		plan_item(compose_marker(16'h5917, 4'b0000, 4'b1001, 0, ROT_180), 1'b0, MARKER_REJECT);
		plan_item(compose_marker(16'h5917, 4'b0000, 4'b1001, 1, ROT_NONE), 1'b1, MARKER_REJECT);
		plan_write(5'd0);
		g = '0;
		g[cell_at(1, 1)] = 1'b1;
		g[cell_at(1, 6)] = 1'b1;
		g[cell_at(6, 1)] = 1'b1;
		plan_item(g, 1'b1, MARKER_REJECT);
		plan_item(compose_marker(16'h0606, 4'b0000, 4'b0100, 8, ROT_90), 1'b0, MARKER_REJECT);
		// Thresholds above the largest possible count reject every grid.
		plan_write(5'd31);
		plan_item(compose_marker(16'h1111, 4'b0000, 4'b1111, 0, ROT_NONE), 1'b1, MARKER_REJECT);

		foreach (plan[n]) begin
			if (plan[n].is_write)
				set_threshold(plan[n].thr);
			else
				feed_grid(plan[n].grid, plan[n].known, plan[n].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_threshold(5'd0);
				1: set_threshold(5'd28);
				2: set_threshold(5'd31);
				3: set_threshold(THR_RESET);
				default: set_threshold(5'($urandom_range(18, 28)));
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 50 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				feed_grid(random_grid(), 1'b0, MARKER_REJECT);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (expected_times.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("led_grid_time_marker_decoder_unit regression: pass");
		else
			$display("led_grid_time_marker_decoder_unit regression: fail");
		$finish;
	end

endmodule
